/* src/integer_to_radix_ascii_defines.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the integer to radix ASCII converter
// Shared concurrent assertion forms, clocked on clk; ITRA_ASSERT is disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef INTEGER_TO_RADIX_ASCII_DEFINES_SVH
`define INTEGER_TO_RADIX_ASCII_DEFINES_SVH

// Assertion that is switched off while reset is held.
`define ITRA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Assertion that also holds during reset.
`define ITRA_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/itra_pkg.sv */
// ---------------------------------------------------------------------------
// itra_pkg
// Types, constants and helpers shared by the radix ASCII converter.
// ---------------------------------------------------------------------------
`default_nettype none

package itra_pkg;

    localparam int VALUE_WIDTH_DEF = 64;
    localparam int STORE_DEPTH     = 64;
    localparam int STORE_AW        = 6;
    localparam int COUNT_W         = 7;
    localparam int DIGIT_W         = 4;
    localparam int CHAR_W          = 7;
    localparam int QUEUE_DEPTH     = 2;

    localparam logic [1:0] BASE_BIN = 2'd0;
    localparam logic [1:0] BASE_OCT = 2'd1;
    localparam logic [1:0] BASE_DEC = 2'd2;
    localparam logic [1:0] BASE_HEX = 2'd3;

    localparam logic [CHAR_W-1:0]  ASCII_ZERO = 7'd48;
    localparam logic [CHAR_W-1:0]  ASCII_A    = 7'd65;
    localparam logic [CHAR_W-1:0]  ASCII_LAST = 7'd70;
    localparam logic [CHAR_W-1:0]  ASCII_NINE = 7'd57;
    localparam logic [DIGIT_W-1:0] DEC_TEN    = 4'd10;

    localparam logic [COUNT_W-1:0] STORE_DEPTH_C = COUNT_W'(STORE_DEPTH);

    // Classified control part of one transaction.
    typedef struct packed {
        logic [1:0]         base_sel;
        logic [COUNT_W-1:0] min_cnt;
    } itra_cls_t;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d < DEC_TEN)
        begin
            c = ASCII_ZERO + CHAR_W'(d);
        end
        else
        begin
            c = ASCII_A + CHAR_W'(d - DEC_TEN);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

/* src/itra_ram.sv */
// ---------------------------------------------------------------------------
// itra_ram
// Generic single write port, single read port RAM with registered read.
// ---------------------------------------------------------------------------
`default_nettype none

module itra_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* src/itra_front.sv */
// ---------------------------------------------------------------------------
// itra_front
// Accepts transactions, masks the value and clamps the digit minimum, then
// holds them in a two-entry queue for the conversion back end.
// ---------------------------------------------------------------------------
`default_nettype none

module itra_front #(
    parameter int VALUE_WIDTH = itra_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic [63:0]                  value,
    input  wire logic [1:0]                   base_sel,
    input  wire logic [itra_pkg::COUNT_W-1:0] min_digits,
    output logic                              q_valid,
    input  wire logic                         q_pop,
    output logic      [VALUE_WIDTH-1:0]       q_value,
    output itra_pkg::itra_cls_t               q_cls
);

    import itra_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

    logic [VALUE_WIDTH-1:0] val_mem [QUEUE_DEPTH];
    itra_cls_t              cls_mem [QUEUE_DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    logic      push;
    logic      pop;
    itra_cls_t cls_in;

    // Clamp the minimum to the store depth; a zero minimum still yields one digit.
    always_comb
    begin
        cls_in.base_sel = base_sel;
        if (min_digits > STORE_DEPTH_C)
        begin
            cls_in.min_cnt = STORE_DEPTH_C;
        end
        else if (min_digits == '0)
        begin
            cls_in.min_cnt = COUNT_W'(1);
        end
        else
        begin
            cls_in.min_cnt = min_digits;
        end
    end

    assign busy    = (cnt_reg == FULL_CNT);
    assign push    = start && !busy;
    assign q_valid = (cnt_reg != '0);
    assign pop     = q_pop && q_valid;
    assign q_value = val_mem[rd_ptr_reg];
    assign q_cls   = cls_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            val_mem[wr_ptr_reg] <= value[VALUE_WIDTH-1:0];
            cls_mem[wr_ptr_reg] <= cls_in;
        end
    end

endmodule

`default_nettype wire

/* src/itra_back.sv */
// ---------------------------------------------------------------------------
// itra_back
// Converts one queued transaction to digits and emits them as ASCII,
// most significant first. Decimal goes through a shift-and-add-3 pass.
// ---------------------------------------------------------------------------
`default_nettype none
`include "integer_to_radix_ascii_defines.svh"

module itra_back #(
    parameter int VALUE_WIDTH = itra_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        q_valid,
    output logic                             q_pop,
    input  wire logic [VALUE_WIDTH-1:0]      q_value,
    input  wire itra_pkg::itra_cls_t         q_cls,
    output logic                             strobe,
    output logic      [itra_pkg::CHAR_W-1:0] char_code,
    output logic                             last
);

    import itra_pkg::*;

    // Enough decimal digits for any VALUE_WIDTH-bit value.
    localparam int BCD_DIGITS = (VALUE_WIDTH * 3) / 10 + 1;
    localparam int WORK_W     = DIGIT_W * BCD_DIGITS;
    localparam int ITER_W     = $clog2(VALUE_WIDTH);
    localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(VALUE_WIDTH - 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_EXTR = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0]             state_reg, state_next;
    logic [WORK_W-1:0]      work_reg, work_next;
    logic [VALUE_WIDTH-1:0] bin_reg, bin_next;
    logic [ITER_W-1:0]      iter_reg, iter_next;
    logic [1:0]             base_reg, base_next;
    logic [COUNT_W-1:0]     min_reg, min_next;
    logic [COUNT_W-1:0]     count_reg, count_next;
    logic [COUNT_W-1:0]     total_reg, total_next;
    logic [STORE_AW-1:0]    idx_reg, idx_next;

    logic                   rd_valid_reg, rd_valid_next;
    logic                   rd_pad_reg, rd_pad_next;
    logic                   rd_last_reg, rd_last_next;
    logic                   strobe_reg;
    logic [CHAR_W-1:0]      char_reg;
    logic                   last_reg;

    logic [WORK_W-1:0]      bcd_adj;
    logic [WORK_W-1:0]      work_shifted;
    logic [DIGIT_W-1:0]     digit;
    logic                   work_nz;
    logic                   store_we;
    logic [COUNT_W-1:0]     total_calc;
    logic [COUNT_W-1:0]     total_m1;
    logic [DIGIT_W-1:0]     rdata;
    logic [DIGIT_W-1:0]     emit_digit;

    // Add 3 to every BCD digit of 5 or more before the shift.
    always_comb
    begin
        for (int i = 0; i < BCD_DIGITS; i++)
        begin
            if (work_reg[i*DIGIT_W +: DIGIT_W] >= DIGIT_W'(5))
            begin
                bcd_adj[i*DIGIT_W +: DIGIT_W] = work_reg[i*DIGIT_W +: DIGIT_W] + DIGIT_W'(3);
            end
            else
            begin
                bcd_adj[i*DIGIT_W +: DIGIT_W] = work_reg[i*DIGIT_W +: DIGIT_W];
            end
        end
    end

    always_comb
    begin
        unique case (base_reg)
            BASE_BIN:
            begin
                digit        = {3'b000, work_reg[0]};
                work_shifted = work_reg >> 1;
            end
            BASE_OCT:
            begin
                digit        = {1'b0, work_reg[2:0]};
                work_shifted = work_reg >> 3;
            end
            BASE_DEC:
            begin
                digit        = work_reg[DIGIT_W-1:0];
                work_shifted = work_reg >> DIGIT_W;
            end
            BASE_HEX:
            begin
                digit        = work_reg[DIGIT_W-1:0];
                work_shifted = work_reg >> DIGIT_W;
            end
        endcase
    end

    assign work_nz    = (work_reg != '0);
    assign store_we   = (state_reg == ST_EXTR) && work_nz && (count_reg < STORE_DEPTH_C);
    assign total_calc = (count_reg > min_reg) ? count_reg : min_reg;
    assign total_m1   = total_calc - COUNT_W'(1);
    assign q_pop      = (state_reg == ST_IDLE) && q_valid;

    always_comb
    begin
        state_next    = state_reg;
        work_next     = work_reg;
        bin_next      = bin_reg;
        iter_next     = iter_reg;
        base_next     = base_reg;
        min_next      = min_reg;
        count_next    = count_reg;
        total_next    = total_reg;
        idx_next      = idx_reg;
        rd_valid_next = 1'b0;
        rd_pad_next   = 1'b0;
        rd_last_next  = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    base_next  = q_cls.base_sel;
                    min_next   = q_cls.min_cnt;
                    count_next = '0;
                    iter_next  = '0;
                    bin_next   = q_value;
                    if (q_cls.base_sel == BASE_DEC)
                    begin
                        work_next  = '0;
                        state_next = ST_CONV;
                    end
                    else
                    begin
                        work_next  = {{(WORK_W - VALUE_WIDTH){1'b0}}, q_value};
                        state_next = ST_EXTR;
                    end
                end
            end
            ST_CONV:
            begin
                work_next = {bcd_adj[WORK_W-2:0], bin_reg[VALUE_WIDTH-1]};
                bin_next  = {bin_reg[VALUE_WIDTH-2:0], 1'b0};
                iter_next = iter_reg + ITER_W'(1);
                if (iter_reg == ITER_LAST)
                begin
                    state_next = ST_EXTR;
                end
            end
            ST_EXTR:
            begin
                if (store_we)
                begin
                    work_next  = work_shifted;
                    count_next = count_reg + COUNT_W'(1);
                end
                else
                begin
                    total_next = total_calc;
                    idx_next   = total_m1[STORE_AW-1:0];
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                rd_valid_next = 1'b1;
                rd_pad_next   = ({1'b0, idx_reg} >= count_reg);
                rd_last_next  = (idx_reg == '0);
                idx_next      = idx_reg - STORE_AW'(1);
                if (idx_reg == '0)
                begin
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    itra_ram #(
        .WIDTH (DIGIT_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (store_we),
        .waddr (count_reg[STORE_AW-1:0]),
        .wdata (digit),
        .raddr (idx_reg),
        .rdata (rdata)
    );

    // Positions above the converted digits are padding zeros.
    assign emit_digit = rd_pad_reg ? '0 : rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            work_reg     <= '0;
            rd_valid_reg <= 1'b0;
            strobe_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            work_reg     <= work_next;
            rd_valid_reg <= rd_valid_next;
            strobe_reg   <= rd_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg     <= bin_next;
        iter_reg    <= iter_next;
        base_reg    <= base_next;
        min_reg     <= min_next;
        total_reg   <= total_next;
        idx_reg     <= idx_next;
        rd_pad_reg  <= rd_pad_next;
        rd_last_reg <= rd_last_next;
        char_reg    <= digit_char(emit_digit);
        last_reg    <= rd_last_reg;
    end

    assign strobe    = strobe_reg;
    assign char_code = char_reg;
    assign last      = last_reg;

    `ITRA_ASSERT(a_emit_idx_in_range, (state_reg == ST_EMIT) |-> ({1'b0, idx_reg} < total_reg), "emit index beyond digit total")
    `ITRA_ASSERT(a_conv_only_decimal, (state_reg == ST_CONV) |-> (base_reg == BASE_DEC), "BCD conversion on a non-decimal transaction")
    `ITRA_ASSERT(a_gap_after_last, (strobe_reg && last_reg) |=> !strobe_reg, "character strobed right after a final character")
    `ITRA_ASSERT(a_char_legal, strobe_reg |-> ((char_reg >= ASCII_ZERO && char_reg <= ASCII_NINE) || (char_reg >= ASCII_A && char_reg <= ASCII_LAST)), "illegal character code")

endmodule

`default_nettype wire

/* src/integer_to_radix_ascii.sv */
// ---------------------------------------------------------------------------
// integer_to_radix_ascii
// Converts unsigned integers to ASCII digits in base 2, 8, 10 or 16.
// Flow: the back end takes a queued item, runs the BCD conversion for base 10,
//   extracts the digits into the store, then reads them out most significant
//   first, padded with zeros up to the minimum.
// Throughput: one character per cycle while a number is emitted; a two-entry queue holds waiting items.
// Reset: asynchronous, clears queue and back-end control; the digit store is
//   not cleared. The receiver cannot stall output.
// ---------------------------------------------------------------------------
`default_nettype none

module integer_to_radix_ascii #(
    parameter int VALUE_WIDTH = itra_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic [63:0]                  value,
    input  wire logic [1:0]                   base_sel,
    input  wire logic [itra_pkg::COUNT_W-1:0] min_digits,
    output logic                              strobe,
    output logic      [itra_pkg::CHAR_W-1:0]  char_code,
    output logic                              last
);

    import itra_pkg::*;

    logic                   q_valid;
    logic                   q_pop;
    logic [VALUE_WIDTH-1:0] q_value;
    itra_cls_t              q_cls;

    itra_front #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .value      (value),
        .base_sel   (base_sel),
        .min_digits (min_digits),
        .q_valid    (q_valid),
        .q_pop      (q_pop),
        .q_value    (q_value),
        .q_cls      (q_cls)
    );

    itra_back #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_value   (q_value),
        .q_cls     (q_cls),
        .strobe    (strobe),
        .char_code (char_code),
        .last      (last)
    );

endmodule

`default_nettype wire

/* bench/tb_integer_to_radix_ascii.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_integer_to_radix_ascii
// Self-checking bench for the radix ASCII converter. A short table of
// directed conversions is followed by random values, bases and minimum
// widths. Every character that leaves the block is compared with the table's
// text or a conversion worked out inside the bench. Requests arrive with random gaps.
// ---------------------------------------------------------------------------

module tb_integer_to_radix_ascii;

    import itra_pkg::*;

    localparam int RANDOM_ITEMS = 350;
    localparam int IDLE_LIMIT   = 4000;
    localparam int DRAIN_CYCLES = 300;

    // One emitted character together with its end-of-number flag.
    typedef struct packed {
        logic              last;
        logic [CHAR_W-1:0] code;
    } digit_beat_t;

    typedef struct {
        logic [63:0]        value;
        logic [1:0]         base_sel;
        logic [COUNT_W-1:0] min_digits;
        string              text;
    } directed_row_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [63:0]        value;
    logic [1:0]         base_sel;
    logic [COUNT_W-1:0] min_digits;
    logic               strobe;
    logic [CHAR_W-1:0]  char_code;
    logic               last;

    digit_beat_t   pending_chars[$];
    directed_row_t directed_rows[$];
    int            mismatch_count;
    int            chars_checked;
    int            values_sent;
    int            base_hits[4];
    int            idle_cycles;
    int            burst_left;

    integer_to_radix_ascii u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .value      (value),
        .base_sel   (base_sel),
        .min_digits (min_digits),
        .strobe     (strobe),
        .char_code  (char_code),
        .last       (last)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    // Converts one value the way the block should and queues its characters.
    function automatic void queue_conversion(input logic [63:0] v, input logic [1:0] b,
                                             input logic [COUNT_W-1:0] m);
        logic [3:0]  digits [64];
        logic [63:0] rest;
        logic [63:0] radix;
        int          n;
        int          want;
        digit_beat_t beat;
        case (b)
            BASE_BIN: radix = 64'd2;
            BASE_OCT: radix = 64'd8;
            BASE_DEC: radix = 64'd10;
            default:  radix = 64'd16;
        endcase
        want = (m > 7'd64) ? 64 : int'(m);
        if (want == 0)
        begin
            want = 1;
        end
        rest = v;
        n = 0;
        while (rest != 64'd0 && n < 64)
        begin
            digits[n] = 4'(rest % radix);
            rest = rest / radix;
            n++;
        end
        while (n < want)
        begin
            digits[n] = 4'd0;
            n++;
        end
        for (int k = n - 1; k >= 0; k--)
        begin
            if (digits[k] < 4'd10)
            begin
                beat.code = ASCII_ZERO + CHAR_W'(digits[k]);
            end
            else
            begin
                beat.code = ASCII_A + CHAR_W'(digits[k] - 4'd10);
            end
            beat.last = (k == 0);
            pending_chars.push_back(beat);
        end
    endfunction

    function automatic void queue_text(input string s);
        digit_beat_t beat;
        byte         ch;
        for (int i = 0; i < s.len(); i++)
        begin
            ch        = s[i];
            beat.code = ch[CHAR_W-1:0];
            beat.last = (i == s.len() - 1);
            pending_chars.push_back(beat);
        end
    endfunction

    function automatic int pick_gap();
        int gap;
        if (burst_left > 0)
        begin
            burst_left--;
            gap = 0;
        end
        else
        begin
            case ($urandom_range(0, 19))
                0:                  gap = 0;
                1, 2, 3, 4, 5,
                6, 7, 8, 9:         gap = $urandom_range(0, 1);
                10, 11, 12, 13, 14,
                15, 16:             gap = $urandom_range(1, 3);
                17:                 gap = $urandom_range(4, 12);
                18:                 gap = $urandom_range(20, 60);
                default:
                begin
                    gap = 0;
                    burst_left = $urandom_range(10, 30);
                end
            endcase
        end
        return gap;
    endfunction

    // Presents one request, waits for it to be taken, then idles for a random gap, which may be zero.
    // An empty text means the expectation comes from queue_conversion.
    task automatic send_conversion(input logic [63:0] v, input logic [1:0] b,
                                   input logic [COUNT_W-1:0] m, input string text);
        int gap;
        @(negedge clk);
        start      <= 1'b1;
        value      <= v;
        base_sel   <= b;
        min_digits <= m;
        do
        begin
            @(posedge clk);
        end
        while (busy);
        if (text.len() > 0)
        begin
            queue_text(text);
        end
        else
        begin
            queue_conversion(v, b, m);
        end
        values_sent++;
        base_hits[b]++;
        gap = pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic add_row(input logic [63:0] v, input logic [1:0] b,
                           input logic [COUNT_W-1:0] m, input string text);
        directed_row_t row;
        row.value      = v;
        row.base_sel   = b;
        row.min_digits = m;
        row.text       = text;
        directed_rows.push_back(row);
    endtask

    function automatic logic [63:0] random_value();
        logic [63:0] full;
        logic [63:0] v;
        full = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = full;
            4, 5, 6:    v = full >> $urandom_range(0, 63);
            7:          v = 64'($urandom_range(0, 20));
            8:          v = ~64'd0 >> $urandom_range(0, 63);
            default:    v = ($urandom_range(0, 1) == 1) ? ~64'd0 : 64'd0;
        endcase
        return v;
    endfunction

    function automatic logic [COUNT_W-1:0] random_min();
        logic [COUNT_W-1:0] m;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: m = COUNT_W'($urandom_range(0, 4));
            6, 7:             m = COUNT_W'($urandom_range(5, 30));
            8:                m = COUNT_W'($urandom_range(31, 64));
            default:          m = COUNT_W'($urandom_range(65, 127));
        endcase
        return m;
    endfunction

    // Result checker and watchdog share the sampling edge.
    always @(posedge clk)
    begin
        digit_beat_t want;
        if (rst_n)
        begin
            if ((start && !busy) || strobe)
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
            if (strobe)
            begin
                if (pending_chars.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected character 0x%0h last=%0b",
                                              char_code, last));
                end
                else
                begin
                    want = pending_chars.pop_front();
                    chars_checked++;
                    if (char_code !== want.code)
                    begin
                        report_mismatch($sformatf("char_code 0x%0h, wanted 0x%0h",
                                                  char_code, want.code));
                    end
                    if (last !== want.last)
                    begin
                        report_mismatch($sformatf("last %0b, wanted %0b on char 0x%0h",
                                                  last, want.last, want.code));
                    end
                end
            end
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("watchdog: %0d cycles without a transaction, %0d chars pending",
                         idle_cycles, pending_chars.size());
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        start          = 1'b0;
        value          = 64'd0;
        base_sel       = BASE_BIN;
        min_digits     = '0;
        mismatch_count = 0;
        chars_checked  = 0;
        values_sent    = 0;
        idle_cycles    = 0;
        burst_left     = 0;
        base_hits      = '{0, 0, 0, 0};

        // Zero with no minimum still gives one digit; minimums above 64 clamp.
        add_row(64'd0, BASE_DEC, 7'd0, "0");
        add_row(64'd0, BASE_BIN, 7'd0, "0");
        add_row(64'd0, BASE_HEX, 7'd5, "00000");
        add_row(~64'd0, BASE_HEX, 7'd0, "FFFFFFFFFFFFFFFF");
        add_row(~64'd0, BASE_DEC, 7'd0, "18446744073709551615");
        add_row(~64'd0, BASE_OCT, 7'd0, "1777777777777777777777");
        add_row(~64'd0, BASE_BIN, 7'd0, "");
        add_row(64'd0, BASE_BIN, 7'd64, "");
        add_row(64'd0, BASE_DEC, 7'd127, "");
        add_row(64'd5, BASE_DEC, 7'd100, "");
        add_row(64'h0000_0000_00AB_CDEF, BASE_HEX, 7'd0, "ABCDEF");
        add_row(64'h0123_4567_89AB_CDEF, BASE_HEX, 7'd0, "123456789ABCDEF");
        add_row(64'd255, BASE_HEX, 7'd4, "00FF");
        add_row(64'd10, BASE_BIN, 7'd0, "1010");
        add_row(64'd8, BASE_OCT, 7'd3, "010");
        add_row(64'd9, BASE_DEC, 7'd1, "9");
        add_row(64'd10, BASE_HEX, 7'd0, "A");
        add_row(64'd15, BASE_HEX, 7'd1, "F");
        add_row(64'd12345, BASE_DEC, 7'd3, "12345");
        add_row(64'h8000_0000_0000_0000, BASE_BIN, 7'd0, "");
        add_row(64'h8000_0000_0000_0000, BASE_HEX, 7'd65, "");
        add_row(64'd1, BASE_BIN, 7'd64, "");
        add_row(64'h5555_5555_5555_5555, BASE_OCT, 7'd64, "");
        add_row(64'hAAAA_AAAA_AAAA_AAAA, BASE_DEC, 7'd20, "");

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_rows[i])
        begin
            send_conversion(directed_rows[i].value, directed_rows[i].base_sel,
                            directed_rows[i].min_digits, directed_rows[i].text);
        end

        repeat (RANDOM_ITEMS)
        begin
            send_conversion(random_value(), 2'($urandom_range(0, 3)), random_min(), "");
        end

        @(negedge clk);
        start <= 1'b0;

        while (pending_chars.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("converted %0d values (bin %0d, oct %0d, dec %0d, hex %0d)",
                 values_sent, base_hits[0], base_hits[1], base_hits[2], base_hits[3]);
        $display("checked %0d characters, %0d mismatches", chars_checked, mismatch_count);
        if (mismatch_count == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

/* integer_to_radix_ascii.f */
+incdir+src
src/itra_pkg.sv
src/itra_ram.sv
src/itra_front.sv
src/itra_back.sv
src/integer_to_radix_ascii.sv
bench/tb_integer_to_radix_ascii.sv
